@@ hdl/bellman_ford_shortest_paths_unit_macros.svh @@
// Assertion macros shared by the shortest-path unit.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_UNIT_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFSP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bfsp_pkg.sv @@
// Shared types and constants of the shortest-path unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package bfsp_pkg;

	localparam int W_MODE = 2;
	localparam int W_VTX = 6;
	localparam int W_NV = 7;
	localparam int W_WEIGHT = 16;
	localparam int W_DIST = 32;
	localparam int W_OUT_DIST = 22;
	localparam int W_EDGE = 2 * W_VTX + W_WEIGHT;

	localparam logic [W_MODE-1:0] MODE_LOAD = 2'd0;
	localparam logic [W_MODE-1:0] MODE_RUN = 2'd1;
	localparam logic [W_MODE-1:0] MODE_CLEAR = 2'd2;

	localparam logic [W_NV-1:0] NV_RESET = 7'd64;

	localparam logic signed [W_DIST-1:0] DIST_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [W_DIST-1:0] DIST_MIN = 32'sh8000_0000;
	localparam logic signed [W_DIST-1:0] OUT_MAX = 32'sd2097151;
	localparam logic signed [W_DIST-1:0] OUT_MIN = -32'sd2097152;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_PASS_START,
		ST_EDGE_RD,
		ST_RELAX,
		ST_CHK_START,
		ST_CHK_RD,
		ST_CHK_EVAL,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EMIT_NEG
	} state_t;

	typedef struct packed {
		logic load_edge;
		logic clear_edges;
		logic run_accept;
		logic run_init;
		logic pass_start;
		logic next_pass;
		logic edge_fetch;
		logic relax_write;
		logic next_edge;
		logic emit_read;
		logic emit_out;
		logic emit_neg;
	} cmd_t;

	typedef struct packed {
		logic no_edges;
		logic passes_done;
		logic last_edge;
		logic relax_hit;
		logic last_vertex;
	} status_t;

endpackage

@@ hdl/bfsp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the edge table and the distance and parent stores; no dependencies.
module bfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/bfsp_ctrl.sv @@
// Controller state machine of the shortest-path unit: sequences loads, relaxation
// passes, the detection pass and the result emission. Depends on bfsp_pkg.
module bfsp_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bfsp_pkg::W_MODE-1:0]       mode,
	input  bfsp_pkg::status_t                 status,
	output logic                              busy,
	output bfsp_pkg::cmd_t                    cmd
);
	import bfsp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load_edge = (mode == MODE_LOAD);
					cmd.clear_edges = (mode == MODE_CLEAR);
					cmd.run_accept = (mode == MODE_RUN);
					if (mode == MODE_RUN) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.run_init = 1'b1;
				state_d = ST_PASS_START;
			end
			ST_PASS_START: begin
				priority if (status.passes_done) begin
					state_d = ST_CHK_START;
				end else if (status.no_edges) begin
					cmd.next_pass = 1'b1;
				end else begin
					cmd.pass_start = 1'b1;
					state_d = ST_EDGE_RD;
				end
			end
			ST_EDGE_RD: begin
				cmd.edge_fetch = 1'b1;
				state_d = ST_RELAX;
			end
			ST_RELAX: begin
				cmd.relax_write = 1'b1;
				if (status.last_edge) begin
					cmd.next_pass = 1'b1;
					state_d = ST_PASS_START;
				end else begin
					cmd.next_edge = 1'b1;
					state_d = ST_EDGE_RD;
				end
			end
			ST_CHK_START: begin
				if (status.no_edges) begin
					state_d = ST_EMIT_RD;
				end else begin
					cmd.pass_start = 1'b1;
					state_d = ST_CHK_RD;
				end
			end
			ST_CHK_RD: begin
				cmd.edge_fetch = 1'b1;
				state_d = ST_CHK_EVAL;
			end
			ST_CHK_EVAL: begin
				priority if (status.relax_hit) begin
					state_d = ST_EMIT_NEG;
				end else if (status.last_edge) begin
					state_d = ST_EMIT_RD;
				end else begin
					cmd.next_edge = 1'b1;
					state_d = ST_CHK_RD;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_read = 1'b1;
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				cmd.emit_out = 1'b1;
				state_d = status.last_vertex ? ST_IDLE : ST_EMIT_RD;
			end
			ST_EMIT_NEG: begin
				cmd.emit_neg = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/bfsp_datapath.sv @@
// Datapath of the shortest-path unit: edge table, distance and parent stores,
// reached flags, counters, relaxation arithmetic and result registers.
// Depends on bfsp_pkg, bfsp_ram and the assertion macro header.
`include "bellman_ford_shortest_paths_unit_macros.svh"

module bfsp_datapath #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bfsp_pkg::cmd_t                         cmd,
	output bfsp_pkg::status_t                      status,
	input  logic [bfsp_pkg::W_VTX-1:0]             edge_src,
	input  logic [bfsp_pkg::W_VTX-1:0]             edge_dest,
	input  logic signed [bfsp_pkg::W_WEIGHT-1:0]   edge_weight,
	input  logic [bfsp_pkg::W_VTX-1:0]             source_vertex,
	input  logic                                   cfg_we,
	input  logic [bfsp_pkg::W_NV-1:0]              cfg_data,
	output logic                                   result_valid,
	output logic [bfsp_pkg::W_VTX-1:0]             vertex,
	output logic [bfsp_pkg::W_VTX-1:0]             parent,
	output logic signed [bfsp_pkg::W_OUT_DIST-1:0] distance,
	output logic                                   reachable,
	output logic                                   negative_cycle,
	output logic                                   last
);
	import bfsp_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NV_CAP = (MAX_VERTICES > 127) ? 127 : MAX_VERTICES;

	logic [W_NV-1:0] num_vertices_q;
	logic [W_NV-1:0] nv;
	logic [EW-1:0] edge_count_q;
	logic [EW-1:0] idx_q;
	logic [EW-1:0] idx_next;
	logic [W_NV-1:0] pass_q;
	logic [W_NV-1:0] k_q;
	logic [W_VTX-1:0] src_q;
	logic [MAX_VERTICES-1:0] reached_q;

	logic [W_VTX-1:0] u_q;
	logic [W_VTX-1:0] v_q;
	logic signed [W_WEIGHT-1:0] w_q;

	logic edge_we;
	logic [EW-1:0] edge_waddr;
	logic [W_EDGE-1:0] edge_wdata;
	logic edge_re;
	logic [EW-1:0] edge_raddr;
	logic [W_EDGE-1:0] edge_rdata;
	logic [W_VTX-1:0] rd_u;
	logic [W_VTX-1:0] rd_v;

	logic src_ok;
	logic init_wr;
	logic upd_wr;
	logic st_we;
	logic [VW-1:0] st_waddr;
	logic [W_DIST-1:0] dist_wdata;
	logic [W_VTX-1:0] pred_wdata;
	logic [VW-1:0] dist_a_raddr;
	logic [W_DIST-1:0] dist_a_rdata;
	logic [W_DIST-1:0] dist_b_rdata;
	logic [W_VTX-1:0] pred_rdata;
	logic [VW-1:0] k_idx;

	logic signed [W_DIST-1:0] du;
	logic signed [W_DIST-1:0] dv;
	logic signed [W_DIST:0] sum;
	logic signed [W_DIST-1:0] cand;
	logic in_range;
	logic hit;
	logic signed [W_DIST-1:0] dk;
	logic signed [W_DIST-1:0] dk_sat;

	always_comb begin
		nv = num_vertices_q;
		if (nv == '0) begin
			nv = 7'd1;
		end else if (nv > W_NV'(NV_CAP)) begin
			nv = W_NV'(NV_CAP);
		end
	end

	assign idx_next = idx_q + EW'(1);
	assign src_ok = ({1'b0, src_q} < nv);

	assign edge_we = cmd.load_edge && (edge_count_q < EW'(MAX_EDGES));
	assign edge_waddr = edge_count_q;
	assign edge_wdata = {edge_src, edge_dest, edge_weight};
	assign edge_re = cmd.pass_start || cmd.edge_fetch;
	assign edge_raddr = cmd.pass_start ? '0 : idx_next;
	assign rd_u = edge_rdata[W_EDGE-1 -: W_VTX];
	assign rd_v = edge_rdata[W_WEIGHT +: W_VTX];

	bfsp_ram #(
		.WIDTH(W_EDGE),
		.DEPTH(MAX_EDGES)
	) u_edge_ram (
		.clk  (clk),
		.we   (edge_we),
		.waddr(edge_waddr[EAW-1:0]),
		.wdata(edge_wdata),
		.re   (edge_re),
		.raddr(edge_raddr[EAW-1:0]),
		.rdata(edge_rdata)
	);

	assign du = dist_a_rdata;
	assign dv = dist_b_rdata;
	assign sum = {du[W_DIST-1], du} + {{(W_DIST + 1 - W_WEIGHT){w_q[W_WEIGHT-1]}}, w_q};
	always_comb begin
		if (sum[W_DIST] != sum[W_DIST-1]) begin
			cand = sum[W_DIST] ? DIST_MIN : DIST_MAX;
		end else begin
			cand = sum[W_DIST-1:0];
		end
	end
	assign in_range = ({1'b0, u_q} < nv) && ({1'b0, v_q} < nv);
	assign hit = in_range && reached_q[VW'(u_q)] && (!reached_q[VW'(v_q)] || (cand < dv));

	assign init_wr = cmd.run_init && src_ok;
	assign upd_wr = cmd.relax_write && hit;
	assign st_we = init_wr || upd_wr;
	assign st_waddr = cmd.run_init ? VW'(src_q) : VW'(v_q);
	assign dist_wdata = cmd.run_init ? '0 : cand;
	assign pred_wdata = cmd.run_init ? '0 : u_q;
	assign k_idx = VW'(k_q);
	assign dist_a_raddr = cmd.emit_read ? k_idx : VW'(rd_u);

	bfsp_ram #(
		.WIDTH(W_DIST),
		.DEPTH(MAX_VERTICES)
	) u_dist_a_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(dist_wdata),
		.re   (cmd.edge_fetch || cmd.emit_read),
		.raddr(dist_a_raddr),
		.rdata(dist_a_rdata)
	);

	bfsp_ram #(
		.WIDTH(W_DIST),
		.DEPTH(MAX_VERTICES)
	) u_dist_b_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(dist_wdata),
		.re   (cmd.edge_fetch),
		.raddr(VW'(rd_v)),
		.rdata(dist_b_rdata)
	);

	bfsp_ram #(
		.WIDTH(W_VTX),
		.DEPTH(MAX_VERTICES)
	) u_pred_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(pred_wdata),
		.re   (cmd.emit_read),
		.raddr(k_idx),
		.rdata(pred_rdata)
	);

	assign dk = dist_a_rdata;
	always_comb begin
		if (dk > OUT_MAX) begin
			dk_sat = OUT_MAX;
		end else if (dk < OUT_MIN) begin
			dk_sat = OUT_MIN;
		end else begin
			dk_sat = dk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= NV_RESET;
			edge_count_q <= '0;
			idx_q <= '0;
			pass_q <= '0;
			k_q <= '0;
			reached_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_vertices_q <= cfg_data;
			end
			if (cmd.clear_edges) begin
				edge_count_q <= '0;
			end else if (edge_we) begin
				edge_count_q <= edge_count_q + EW'(1);
			end
			if (cmd.run_accept) begin
				pass_q <= 7'd1;
				k_q <= '0;
			end else begin
				if (cmd.next_pass) begin
					pass_q <= pass_q + 7'd1;
				end
				if (cmd.emit_out) begin
					k_q <= k_q + 7'd1;
				end
			end
			if (cmd.pass_start) begin
				idx_q <= '0;
			end else if (cmd.next_edge) begin
				idx_q <= idx_next;
			end
			if (cmd.run_init) begin
				reached_q <= src_ok ? (MAX_VERTICES'(1) << src_q) : '0;
			end else if (upd_wr) begin
				reached_q[VW'(v_q)] <= 1'b1;
			end
			result_valid <= cmd.emit_out || cmd.emit_neg;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_accept) begin
			src_q <= source_vertex;
		end
		if (cmd.edge_fetch) begin
			u_q <= rd_u;
			v_q <= rd_v;
			w_q <= edge_rdata[W_WEIGHT-1:0];
		end
		if (cmd.emit_out) begin
			vertex <= W_VTX'(k_q);
			reachable <= reached_q[k_idx];
			parent <= reached_q[k_idx] ? pred_rdata : '0;
			distance <= reached_q[k_idx] ? dk_sat[W_OUT_DIST-1:0] : '0;
			negative_cycle <= 1'b0;
			last <= (k_q + 7'd1 == nv);
		end else if (cmd.emit_neg) begin
			vertex <= '0;
			reachable <= 1'b0;
			parent <= '0;
			distance <= '0;
			negative_cycle <= 1'b1;
			last <= 1'b1;
		end
	end

	assign status.no_edges = (edge_count_q == '0);
	assign status.passes_done = (pass_q >= nv);
	assign status.last_edge = (idx_next == edge_count_q);
	assign status.relax_hit = hit;
	assign status.last_vertex = (k_q + 7'd1 == nv);

	`BFSP_ASSERT_SAME(a_count_bound, 1'b1, edge_count_q <= EW'(MAX_EDGES), "edge count past capacity")
	`BFSP_ASSERT_SAME(a_neg_is_last, result_valid && negative_cycle, last && !reachable, "negative cycle item not final")
	`BFSP_ASSERT_SAME(a_unreached_zero, result_valid && !reachable, distance == '0 && parent == '0, "unreached vertex has data")
	`BFSP_ASSERT_NEXT(a_emit_strobe, cmd.emit_out || cmd.emit_neg, result_valid, "result strobe missing")

endmodule

@@ hdl/bellman_ford_shortest_paths_unit.sv @@
// Top level of the single-source shortest-path unit.
// Depends on bfsp_pkg, bfsp_ctrl and bfsp_datapath.
//
// An item is taken when start is high and busy is low. Mode load stores one
// edge in the next free table slot (dropped when the table is full), mode clear
// empties the table; both finish in the accepting cycle and leave busy low.
// Mode run computes shortest paths from source_vertex over the stored edges.
// A run holds busy high through V-1 relaxation passes over the stored edges,
// one detection pass and the result emission, where V is the active vertex
// count; each edge step reads the distance stores (ST_EDGE_RD), then compares
// and writes back (ST_RELAX).
// Results appear one per strobe on result_valid, each on the ports for one
// cycle: either one negative cycle item, or V vertex items in vertex order,
// the final one marked by last. The receiver cannot stall; every result is
// taken in the cycle it is shown.
// num_vertices is written through cfg_we and cfg_data by the user, only while
// the unit is idle; the block does not enforce it. Reset clears the edge table
// count, the reached flags and the controller, and sets the vertex count to 64.
module bellman_ford_shortest_paths_unit #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [bfsp_pkg::W_MODE-1:0]            mode,
	input  logic [bfsp_pkg::W_VTX-1:0]             edge_src,
	input  logic [bfsp_pkg::W_VTX-1:0]             edge_dest,
	input  logic signed [bfsp_pkg::W_WEIGHT-1:0]   edge_weight,
	input  logic [bfsp_pkg::W_VTX-1:0]             source_vertex,
	input  logic                                   cfg_we,
	input  logic [bfsp_pkg::W_NV-1:0]              cfg_data,
	output logic                                   result_valid,
	output logic [bfsp_pkg::W_VTX-1:0]             vertex,
	output logic [bfsp_pkg::W_VTX-1:0]             parent,
	output logic signed [bfsp_pkg::W_OUT_DIST-1:0] distance,
	output logic                                   reachable,
	output logic                                   negative_cycle,
	output logic                                   last
);
	import bfsp_pkg::*;

	cmd_t cmd;
	status_t status;

	bfsp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (mode),
		.status(status),
		.busy  (busy),
		.cmd   (cmd)
	);

	bfsp_datapath #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.edge_src      (edge_src),
		.edge_dest     (edge_dest),
		.edge_weight   (edge_weight),
		.source_vertex (source_vertex),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.vertex        (vertex),
		.parent        (parent),
		.distance      (distance),
		.reachable     (reachable),
		.negative_cycle(negative_cycle),
		.last          (last)
	);

endmodule
